### hw/rtl/neuron_prune_bias_fold_macros.svh
// assertion macros for the neuron pruning and bias folding block
// used by the port checker; expects clk_i and rst_ni in scope
`ifndef NEURON_PRUNE_BIAS_FOLD_MACROS_SVH
`define NEURON_PRUNE_BIAS_FOLD_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define NPBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define NPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/npbf_pkg.sv
// shared constants and types for the neuron pruning and bias folding block
// no dependencies
package npbf_pkg;

  // network size and derived widths
  localparam int MaxNeurons = 16;
  localparam int IdxW       = $clog2(MaxNeurons);
  localparam int CntW       = IdxW + 1;
  localparam int WAddrW     = 2 * IdxW;
  localparam int DataW      = 32;
  localparam int ThrW       = 31;
  localparam int ProdW      = 2 * DataW;
  localparam int AccW       = 54;

  // command codes
  localparam logic [1:0] CmdLoadNeuron = 2'd0;
  localparam logic [1:0] CmdLoadWeight = 2'd1;
  localparam logic [1:0] CmdRead       = 2'd2;

  // configuration register indexes
  localparam logic CfgThreshold   = 1'b0;
  localparam logic CfgNeuronCount = 1'b1;

  // one stored neuron record
  typedef struct packed {
    logic [DataW-1:0] activity;
    logic [DataW-1:0] bias;
    logic [DataW-1:0] tau;
    logic [DataW-1:0] gain;
    logic [DataW-1:0] init;
    logic [DataW-1:0] avg;
  } nrec_t;

endpackage

### hw/rtl/neuron_prune_bias_fold.sv
// neuron pruning with bias folding: record and weight memories plus read sequencer
// depends on npbf_pkg
//
// Usage: configure activity threshold (index 0) and neuron count (index 1)
// through the write port while idle. Each transaction on start_i carries a
// command: load neuron record, load weight, or read one pruned entry. A
// transaction is taken when start_i is high and busy_o is low.
// Loads write a memory in the accepting cycle and never raise busy_o, so a
// load may follow every cycle. A read walks the n stored records once to
// find kept neurons (one record memory read per cycle), then walks
// them again reading one weight and one average output per cycle through a
// registered multiplier to fold pruned neurons into the bias.
// The result appears on the output ports with done_o high for exactly one
// cycle: after the first walk for an out-of-range read, after the second
// walk and the multiplier drain for an in-range read.
// The receiver cannot stall; done_o is a strobe. Reset clears control
// state and configuration (threshold 0, neuron count 16); the memories
// hold nothing defined until loaded.
module neuron_prune_bias_fold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [npbf_pkg::ThrW-1:0]     cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    command_i,
  input  logic [npbf_pkg::IdxW-1:0]     row_i,
  input  logic [npbf_pkg::IdxW-1:0]     column_i,
  input  logic signed [31:0]            activity_i,
  input  logic signed [31:0]            bias_in_i,
  input  logic signed [31:0]            tau_in_i,
  input  logic signed [31:0]            gain_in_i,
  input  logic signed [31:0]            init_in_i,
  input  logic signed [31:0]            avg_output_i,
  input  logic signed [31:0]            weight_in_i,
  output logic                          done_o,
  output logic                          valid_res_o,
  output logic [npbf_pkg::CntW-1:0]     kept_count_o,
  output logic [npbf_pkg::IdxW-1:0]     source_neuron_o,
  output logic signed [31:0]            new_bias_o,
  output logic signed [31:0]            new_tau_o,
  output logic signed [31:0]            new_gain_o,
  output logic signed [31:0]            new_init_o,
  output logic signed [31:0]            new_weight_o
);
  import npbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_CHECK,
    ST_FETCH,
    ST_FOLD,
    ST_DRAIN
  } state_e;

  state_e state_q;

  // configuration
  logic [ThrW-1:0] thr_q;
  logic [CntW-1:0] ncount_q;

  // memories and their registered read data
  nrec_t            mem_nrec [MaxNeurons];
  logic [DataW-1:0] mem_wt   [MaxNeurons*MaxNeurons];
  nrec_t            nrec_rd_q;
  logic [DataW-1:0] wt_rd_q;

  logic              n_we, n_re, w_we, w_re;
  logic [IdxW-1:0]   n_raddr;
  logic [WAddrW-1:0] w_raddr;
  nrec_t             n_wdata;

  // sequencer registers
  logic [IdxW-1:0]       cnt_q;
  logic [IdxW-1:0]       row_q, col_q, src_q, dst_q;
  logic [CntW-1:0]       k_q;
  logic [MaxNeurons-1:0] keep_q;
  logic                  sc_vld_q;
  logic [IdxW-1:0]       sc_idx_q;
  logic                  f1_vld_q;
  logic [IdxW-1:0]       f1_idx_q;
  logic signed [ProdW-1:0] prod_q;
  logic                  prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic [DataW-1:0]      tau_q, gain_q, init_q, wsd_q;

  // result registers
  logic              done_q, valid_res_q;
  logic [CntW-1:0]   kept_q;
  logic [IdxW-1:0]   srcn_q;
  logic [DataW-1:0]  bias_res_q, tau_res_q, gain_res_q, init_res_q, wt_res_q;

  // derived values
  logic [CntW-1:0]  n_eff;
  logic [IdxW-1:0]  last_idx;
  logic [DataW-1:0] act_mag;
  logic             sc_keep;
  logic             accept;
  logic             out_of_range;
  logic             sat_hi, sat_lo;
  logic [DataW-1:0] acc_sat;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // clamp neuron count to the supported range
  always_comb begin
    if (ncount_q < CntW'(2)) begin
      n_eff = CntW'(2);
    end else if (ncount_q > CntW'(MaxNeurons)) begin
      n_eff = CntW'(MaxNeurons);
    end else begin
      n_eff = ncount_q;
    end
    last_idx = IdxW'(n_eff - CntW'(1));
  end

  // keep decision for the record arriving from the scan read
  always_comb begin
    act_mag = nrec_rd_q.activity[DataW-1] ? (~nrec_rd_q.activity + DataW'(1))
                                          : nrec_rd_q.activity;
    sc_keep = (sc_idx_q == '0) || (sc_idx_q == last_idx) || (act_mag > {1'b0, thr_q});
  end

  assign out_of_range = ({1'b0, row_q} >= k_q) || ({1'b0, col_q} >= k_q);

  // saturate the folded sum to 32 bits
  always_comb begin
    sat_hi = !acc_q[AccW-1] && (|acc_q[AccW-2:DataW-1]);
    sat_lo = acc_q[AccW-1] && !(&acc_q[AccW-2:DataW-1]);
    if (sat_hi) begin
      acc_sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (sat_lo) begin
      acc_sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      acc_sat = acc_q[DataW-1:0];
    end
  end

  // memory port control
  always_comb begin
    n_we    = accept && (command_i == CmdLoadNeuron);
    w_we    = accept && (command_i == CmdLoadWeight);
    n_wdata = '{activity: activity_i, bias: bias_in_i, tau: tau_in_i,
                gain: gain_in_i, init: init_in_i, avg: avg_output_i};
    n_re    = 1'b0;
    w_re    = 1'b0;
    n_raddr = cnt_q;
    w_raddr = {cnt_q, src_q};
    unique case (state_q)
      ST_SCAN: begin
        n_re = 1'b1;
      end
      ST_CHECK: begin
        n_re    = !out_of_range;
        w_re    = !out_of_range;
        n_raddr = src_q;
        w_raddr = {src_q, dst_q};
      end
      ST_FETCH: begin
        n_re    = 1'b1;
        w_re    = 1'b1;
        n_raddr = '0;
        w_raddr = {{IdxW{1'b0}}, src_q};
      end
      ST_FOLD: begin
        n_re = 1'b1;
        w_re = 1'b1;
      end
      default: begin
        n_re = 1'b0;
      end
    endcase
  end

  // record memory; writes only while idle, reads only while busy, so no overlap
  always_ff @(posedge clk_i) begin
    if (n_we) begin
      mem_nrec[row_i] <= n_wdata;
    end
    if (n_re) begin
      nrec_rd_q <= mem_nrec[n_raddr];
    end
  end

  // weight memory, row major by source neuron
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      mem_wt[{row_i, column_i}] <= weight_in_i;
    end
    if (w_re) begin
      wt_rd_q <= mem_wt[w_raddr];
    end
  end

  // fold datapath: product register, then accumulate floor(product / 2^16)
  always_ff @(posedge clk_i) begin
    if (f1_vld_q) begin
      prod_q <= $signed(wt_rd_q) * $signed(nrec_rd_q.avg);
    end
  end

  // sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      ncount_q    <= CntW'(MaxNeurons);
      cnt_q       <= '0;
      k_q         <= '0;
      keep_q      <= '0;
      sc_vld_q    <= 1'b0;
      f1_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      // strobes and read-data valid flags follow the state
      done_q     <= ((state_q == ST_CHECK) && out_of_range) ||
                    ((state_q == ST_DRAIN) && !f1_vld_q && !prod_vld_q);
      sc_vld_q   <= (state_q == ST_SCAN);
      f1_vld_q   <= (state_q == ST_FETCH) || (state_q == ST_FOLD);
      prod_vld_q <= f1_vld_q && !keep_q[f1_idx_q];

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgThreshold:   thr_q    <= cfg_data_i;
          CfgNeuronCount: ncount_q <= cfg_data_i[CntW-1:0];
          default:        thr_q    <= thr_q;
        endcase
      end

      // keep bits and index mapping from the scan walk
      if (sc_vld_q) begin
        keep_q[sc_idx_q] <= sc_keep;
        if (sc_keep) begin
          if (k_q[IdxW-1:0] == row_q) begin
            src_q <= sc_idx_q;
          end
          if (k_q[IdxW-1:0] == col_q) begin
            dst_q <= sc_idx_q;
          end
          k_q <= k_q + CntW'(1);
        end
      end

      // accumulate folded terms
      if (prod_vld_q) begin
        acc_q <= acc_q + {{(AccW-(ProdW-16)){prod_q[ProdW-1]}}, prod_q[ProdW-1:16]};
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && (command_i == CmdRead)) begin
            row_q   <= row_i;
            col_q   <= column_i;
            src_q   <= '0;
            dst_q   <= '0;
            k_q     <= '0;
            keep_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sc_idx_q <= cnt_q;
          cnt_q    <= cnt_q + IdxW'(1);
          if (cnt_q == last_idx) begin
            state_q <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (out_of_range) begin
            valid_res_q <= 1'b0;
            kept_q      <= k_q;
            srcn_q      <= '0;
            bias_res_q  <= '0;
            tau_res_q   <= '0;
            gain_res_q  <= '0;
            init_res_q  <= '0;
            wt_res_q    <= '0;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          tau_q    <= nrec_rd_q.tau;
          gain_q   <= nrec_rd_q.gain;
          init_q   <= nrec_rd_q.init;
          wsd_q    <= wt_rd_q;
          acc_q    <= {{(AccW-DataW){nrec_rd_q.bias[DataW-1]}}, nrec_rd_q.bias};
          f1_idx_q <= '0;
          cnt_q    <= IdxW'(1);
          state_q  <= ST_FOLD;
        end
        ST_FOLD: begin
          f1_idx_q <= cnt_q;
          cnt_q    <= cnt_q + IdxW'(1);
          if (cnt_q == last_idx) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!f1_vld_q && !prod_vld_q) begin
            valid_res_q <= 1'b1;
            kept_q      <= k_q;
            srcn_q      <= src_q;
            bias_res_q  <= acc_sat;
            tau_res_q   <= tau_q;
            gain_res_q  <= gain_q;
            init_res_q  <= init_q;
            wt_res_q    <= wsd_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign done_o          = done_q;
  assign valid_res_o     = valid_res_q;
  assign kept_count_o    = kept_q;
  assign source_neuron_o = srcn_q;
  assign new_bias_o      = bias_res_q;
  assign new_tau_o       = tau_res_q;
  assign new_gain_o      = gain_res_q;
  assign new_init_o      = init_res_q;
  assign new_weight_o    = wt_res_q;

endmodule

### hw/rtl/npbf_checker.sv
// port-level checker for the neuron pruning and bias folding block, with its bind
// depends on npbf_pkg and neuron_prune_bias_fold_macros.svh
`include "neuron_prune_bias_fold_macros.svh"

module npbf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic [1:0]                command_i,
  input logic                      done_o,
  input logic [npbf_pkg::CntW-1:0] kept_count_o
);
  import npbf_pkg::*;

  // a result strobe lasts one cycle
  `NPBF_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "done_o held for more than one cycle")

  // an accepted read transaction occupies the block
  `NPBF_ASSERT_NEXT(a_read_busy, start_i && !busy_o && command_i == CmdRead, busy_o, "read not taken")

  // loads and unused commands give no result
  `NPBF_ASSERT_NEXT(a_load_quiet, start_i && !busy_o && command_i != CmdRead, !done_o, "result after load")

  // first and last neurons always stay, so the pruned size lies in range
  `NPBF_ASSERT_SAME(a_kept_range, done_o, kept_count_o >= CntW'(2) && kept_count_o <= CntW'(MaxNeurons), "kept count out of range")

endmodule

bind neuron_prune_bias_fold npbf_checker u_npbf_checker (.*);
